[sv/prbe_pkg.sv]
// Package for the predictive row bit-pack encoder: widths and constants.
// No dependencies.
package prbe_pkg;
  localparam int MAX_WIDTH_DEF = 32;
  localparam int PIX_W = 8;
  localparam int WIDTH_W = 6;
  localparam int HEIGHT_W = 16;
  localparam int NLEN_W = 4;
  localparam logic [0:0] REG_WIDTH = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  // bit length of an 8-bit value
  function automatic logic [NLEN_W-1:0] bit_len8(input logic [PIX_W-1:0] v);
    logic [NLEN_W-1:0] n;
    n = '0;
    for (int k = 0; k < PIX_W; k++) begin
      if (v[k]) n = NLEN_W'(k + 1);
    end
    return n;
  endfunction
endpackage

[sv/prbe_packer.sv]
// Bit packer: shifts fields MSB first into bytes, one field per cycle while the output is not stalled.
// Depends on prbe_pkg.
module prbe_packer
  import prbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fld_valid,
  input  logic [7:0] fld_value,
  input  logic [3:0] fld_len,
  input  logic       fld_pad,
  input  logic       fld_last,
  input  logic       fld_eoi,
  output logic       fld_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_end_of_image
);
  logic [14:0] acc_r;
  logic [3:0]  cnt_r;
  logic        ov_r, ol_r, oe_r, hv_r;
  logic [7:0]  ob_r, hb_r;
  logic [14:0] merged;
  logic [4:0]  tot;
  logic [7:0]  nb;
  logic        take;
  logic        ov_nxt, ol_nxt, oe_nxt, hv_nxt;
  logic [7:0]  ob_nxt, hb_nxt;
  logic [3:0]  cnt_nxt;

  assign out_valid = ov_r;
  assign out_byte = ob_r;
  assign out_last_of_run = ol_r;
  assign out_end_of_image = oe_r;
  // pending bits never exceed 7, so one field yields at most one byte
  assign fld_ready = !ov_r || out_ready;
  assign take = fld_valid && fld_ready;

  always_comb begin
    merged = acc_r;
    tot = {1'b0, cnt_r} + {1'b0, fld_len};
    for (int k = 0; k < 8; k++) begin
      if (k < 32'(fld_len)) merged = {merged[13:0], fld_value[32'(fld_len) - 1 - k]};
    end
    // pad to a byte boundary
    if (fld_pad && tot[2:0] != 3'd0) begin
      merged = merged << (5'd8 - {2'b0, tot[2:0]});
      tot = {tot[4:3] + 2'd1, 3'd0};
    end
    nb = 8'(merged >> (tot - 5'd8));
  end

  // a new byte waits in the hold register until the next byte or the
  // closing field shows whether it ends the run
  always_comb begin
    ov_nxt = ov_r && !out_ready;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    oe_nxt = oe_r;
    hv_nxt = hv_r;
    hb_nxt = hb_r;
    cnt_nxt = cnt_r;
    if (take) begin
      if (fld_last) begin
        if (hv_r) begin
          ov_nxt = 1'b1;
          ob_nxt = hb_r;
          ol_nxt = 1'b1;
          oe_nxt = fld_eoi;
          hv_nxt = 1'b0;
        end
      end else if (tot >= 5'd8) begin
        if (hv_r) begin
          ov_nxt = 1'b1;
          ob_nxt = hb_r;
          ol_nxt = 1'b0;
          oe_nxt = 1'b0;
        end
        hv_nxt = 1'b1;
        hb_nxt = nb;
        cnt_nxt = 4'(tot - 5'd8);
      end else begin
        cnt_nxt = tot[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      ob_r <= '0;
      ol_r <= 1'b0;
      oe_r <= 1'b0;
      hv_r <= 1'b0;
      hb_r <= '0;
      cnt_r <= '0;
      acc_r <= '0;
    end else begin
      ov_r <= ov_nxt;
      ob_r <= ob_nxt;
      ol_r <= ol_nxt;
      oe_r <= oe_nxt;
      hv_r <= hv_nxt;
      hb_r <= hb_nxt;
      cnt_r <= cnt_nxt;
      if (take) acc_r <= merged;
    end
  end
endmodule

[sv/predictive_row_bitpack_encoder.sv]
// Top level: predictor, row buffers and emit sequencer over the bit packer.
// Depends on prbe_pkg and prbe_packer.
//  channel | ports                               | handshake
//  in      | in_pixel                            | in_valid/in_ready
//  out     | out_byte, out_last_of_run, out_end_of_image | out_valid/out_ready
//  cfg     | cfg_we, cfg_index, cfg_data         | write on cfg_we
// A pixel is taken in S_IDLE, which reads its neighbors, then S_PRED predicts and stores it.
// A row end sends its fields through the shared packer in order: the minimum, the
// residual length, one residual per pixel, a pad field on the last row, and a closing
// field that releases the held final byte; output stalls hold the packer.
// Synchronous active-low reset clears all counters; row stores stay unset.
module predictive_row_bitpack_encoder
  import prbe_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_pixel,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last_of_run,
  output logic          out_end_of_image,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic [2:0] {S_IDLE, S_PRED, S_MIN, S_LEN, S_RES, S_PAD, S_END} state_t;
  state_t state_r;

  logic [7:0] prev_mem [MAX_WIDTH];
  logic [7:0] cur_mem  [MAX_WIDTH];
  logic [7:0] res_mem  [MAX_WIDTH];

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [CW-1:0]       col_r, j_r;
  logic [16:0]         row_r;
  logic [7:0]          min_r, max_r, pix_r;
  logic [7:0]          up_r, ul_r, left_r, resq_r;
  logic [3:0]          n_r;
  logic                eoi_r;

  logic [6:0]  w_eff;
  logic [16:0] h_eff;
  logic [9:0]  sum;
  logic [1:0]  cnt;
  logic [7:0]  pred, res;
  logic        row_end, has_up;

  logic       fv, fp, fl, fe, frdy;
  logic [7:0] fval;
  logic [3:0] flen;

  assign in_ready = (state_r == S_IDLE);
  assign has_up = (row_r != 17'd0);
  assign w_eff = (width_r == '0) ? 7'd1 :
                 (7'(width_r) > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : 7'(width_r);
  assign h_eff = (height_r == '0) ? 17'h10000 : 17'(height_r);
  assign row_end = (7'(col_r) + 7'd1 >= w_eff);

  // average predictor; divide by three via reciprocal
  always_comb begin
    sum = '0;
    cnt = '0;
    if (has_up) begin sum = sum + 10'(up_r); cnt = cnt + 2'd1; end
    if (col_r != '0) begin sum = sum + 10'(left_r); cnt = cnt + 2'd1; end
    if (has_up && col_r != '0) begin sum = sum + 10'(ul_r); cnt = cnt + 2'd1; end
    case (cnt)
      2'd1: pred = sum[7:0];
      2'd2: pred = sum[8:1];
      2'd3: pred = 8'((20'(sum) * 20'd683) >> 11);
      default: pred = 8'd0;
    endcase
    res = pix_r - pred;
  end

  // field mux to packer
  always_comb begin
    fv = 1'b0; fval = '0; flen = '0; fp = 1'b0; fl = 1'b0; fe = 1'b0;
    case (state_r)
      S_MIN: begin fv = 1'b1; fval = min_r; flen = 4'd8; end
      S_LEN: begin fv = 1'b1; fval = {4'd0, n_r}; flen = 4'd4; end
      S_RES: begin fv = 1'b1; fval = resq_r - min_r; flen = n_r; end
      S_PAD: begin fv = 1'b1; fp = 1'b1; end
      S_END: begin fv = 1'b1; fl = 1'b1; fe = eoi_r; end
      default: ;
    endcase
  end

  prbe_packer u_pack (
    .clk, .rst_n,
    .fld_valid(fv), .fld_value(fval), .fld_len(flen), .fld_pad(fp),
    .fld_last(fl), .fld_eoi(fe), .fld_ready(frdy),
    .out_valid, .out_ready, .out_byte, .out_last_of_run, .out_end_of_image
  );

  // row stores
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      up_r <= prev_mem[col_r];
      ul_r <= prev_mem[(col_r == '0) ? col_r : col_r - CW'(1)];
      left_r <= cur_mem[(col_r == '0) ? col_r : col_r - CW'(1)];
    end
    if (state_r == S_PRED) begin
      cur_mem[col_r] <= pix_r;
      res_mem[col_r] <= res;
    end
    if (state_r == S_LEN || (state_r == S_RES && frdy)) begin
      resq_r <= res_mem[(state_r == S_LEN) ? '0 : j_r + CW'(1)];
      prev_mem[j_r] <= cur_mem[j_r];
    end
  end

  // config and sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      width_r <= 6'd32;
      height_r <= 16'd1;
      col_r <= '0;
      row_r <= '0;
      min_r <= '0;
      max_r <= '0;
      j_r <= '0;
      eoi_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) width_r <= cfg_data[WIDTH_W-1:0];
        else height_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: if (in_valid) begin pix_r <= in_pixel; state_r <= S_PRED; end
        S_PRED: begin
          if (col_r == '0 || res < min_r) min_r <= res;
          if (col_r == '0 || res > max_r) max_r <= res;
          if (row_end) begin
            state_r <= S_MIN;
            eoi_r <= (row_r + 17'd1 >= h_eff);
          end else begin
            col_r <= col_r + CW'(1);
            state_r <= S_IDLE;
          end
        end
        S_MIN: if (frdy) begin n_r <= bit_len8(max_r - min_r); state_r <= S_LEN; end
        S_LEN: if (frdy) begin j_r <= '0; state_r <= S_RES; end
        S_RES: if (frdy) begin
          if (j_r == col_r) begin
            if (eoi_r) state_r <= S_PAD;
            else state_r <= S_END;
          end else j_r <= j_r + CW'(1);
        end
        S_PAD: if (frdy) state_r <= S_END;
        // closing field: flags the final byte of the row
        S_END: if (frdy) begin
          state_r <= S_IDLE;
          col_r <= '0;
          row_r <= eoi_r ? 17'd0 : row_r + 17'd1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // no input accepted while a row is being emitted
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES) |-> !in_ready) else $error("ready during emit");
  // end of image byte is always a last byte
  a_eoi: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_image) |-> out_last_of_run) else $error("eoi w/o last");
  // column always stays below MAX_WIDTH
  a_col: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < MAX_WIDTH)) else $error("column overflow");
endmodule

[sim/tb_predictive_row_bitpack_encoder.sv]
// Testbench for the predictive row bit-pack encoder: drives pixels, predicts the
// packed byte stream and checks every output word. Depends on prbe_pkg and the DUT.
`timescale 1ns / 1ps

module tb_predictive_row_bitpack_encoder
  import prbe_pkg::*;
();

  localparam int ROWBUF = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eoi;
  } word_t;

  typedef enum logic [1:0] {ST_SET_W, ST_SET_H, ST_PIXEL} step_kind_t;

  typedef struct {
    step_kind_t kind;
    logic [15:0] value;
    bit          typed;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
  } dir_step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_pixel = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic        out_end_of_image;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_WIDTH;
  logic [15:0] cfg_data = '0;

  predictive_row_bitpack_encoder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_last_of_run(out_last_of_run), .out_end_of_image(out_end_of_image),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // encoder model state
  logic [7:0]  up_row [ROWBUF];
  logic [7:0]  this_row [ROWBUF];
  logic [7:0]  resid_row [ROWBUF];
  int          col_pos, row_pos;
  logic [7:0]  row_lo, row_hi;
  logic [7:0]  spill_bits;
  int          spill_cnt;
  logic [5:0]  width_reg;
  logic [15:0] height_reg;

  word_t       row_words[$];
  word_t       pending_words[$];

  int  mismatches = 0;
  int  words_seen = 0;
  int  pixels_sent = 0;
  int  images_done = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;

  // append bits MSB first, cutting full bytes into row_words
  task automatic pack_bits(input logic [7:0] value, input int nbits);
    int k;
    for (k = 0; k < nbits; k++) begin
      spill_bits = {spill_bits[6:0], value[nbits-1-k]};
      spill_cnt++;
      if (spill_cnt == 8) begin
        row_words.push_back('{data: spill_bits, last: 1'b0, eoi: 1'b0});
        spill_bits = '0;
        spill_cnt = 0;
      end
    end
  endtask

  // predict one pixel; leaves the row-end words (if any) in row_words
  task automatic encode_pixel(input logic [7:0] pix);
    int w, h, col, sum, cnt, n, j;
    logic [7:0] pred, res, span;
    row_words.delete();
    w = (width_reg == 0) ? 1 : ((width_reg > ROWBUF) ? ROWBUF : int'(width_reg));
    h = (height_reg == 0) ? 65536 : int'(height_reg);
    col = (col_pos >= ROWBUF) ? ROWBUF - 1 : col_pos;
    sum = 0;
    cnt = 0;
    if (row_pos > 0) begin
      sum += up_row[col];
      cnt++;
    end
    if (col > 0) begin
      sum += this_row[col-1];
      cnt++;
    end
    if (row_pos > 0 && col > 0) begin
      sum += up_row[col-1];
      cnt++;
    end
    pred = (cnt != 0) ? 8'(sum / cnt) : 8'd0;
    res = pix - pred;
    this_row[col] = pix;
    resid_row[col] = res;
    if (col == 0) begin
      row_lo = res;
      row_hi = res;
    end else begin
      if (res < row_lo) row_lo = res;
      if (res > row_hi) row_hi = res;
    end
    if (col + 1 < w) begin
      col_pos = col + 1;
      return;
    end
    span = row_hi - row_lo;
    n = 0;
    for (j = 0; j < 8; j++) if (span[j]) n = j + 1;
    pack_bits(row_lo, 8);
    pack_bits(8'(n), 4);
    for (j = 0; j <= col; j++) pack_bits(resid_row[j] - row_lo, n);
    for (j = 0; j < ROWBUF; j++) up_row[j] = this_row[j];
    col_pos = 0;
    if (row_pos + 1 >= h) begin
      if (spill_cnt != 0) pack_bits(8'd0, 8 - spill_cnt);
      row_pos = 0;
      images_done++;
      if (row_words.size() > 0) row_words[row_words.size()-1].eoi = 1'b1;
    end else begin
      row_pos = (row_pos + 1) & 16'hFFFF;
    end
    if (row_words.size() > 0) row_words[row_words.size()-1].last = 1'b1;
  endtask

  // wait for the encoder to drain before touching registers
  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
    // stop offering words before the registers change
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) width_reg = data[5:0];
    else height_reg = data;
  endtask

  // one word on the input channel, with optional idle burst ahead of it
  task automatic send_pixel(input logic [7:0] pix);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_pixel <= pix;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    encode_pixel(pix);
    foreach (row_words[i]) pending_words.push_back(row_words[i]);
  endtask

  task automatic lower_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // pixel pattern generator
  function automatic logic [7:0] next_pixel(input int mode, input int idx,
                                            input logic [7:0] base);
    case (mode)
      0: return 8'($urandom);
      1: return base + 8'($urandom_range(0, 6)) - 8'd3;
      2: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default: return base + 8'(idx * 3);
    endcase
  endfunction

  // sends whole images at the given register values
  task automatic run_phase(input logic [15:0] wdata, input logic [15:0] hdata,
                           input int images);
    int w, h, total, i, mode;
    logic [7:0] base;
    write_reg(REG_WIDTH, wdata);
    write_reg(REG_HEIGHT, hdata);
    w = (wdata[5:0] == 0) ? 1 : ((wdata[5:0] > ROWBUF) ? ROWBUF : int'(wdata[5:0]));
    h = (hdata == 0) ? 65536 : int'(hdata);
    total = w * h * images;
    mode = $urandom_range(0, 3);
    base = 8'($urandom);
    for (i = 0; i < total; i++) begin
      if (i % w == 0 && $urandom_range(0, 2) == 0) mode = $urandom_range(0, 3);
      send_pixel(next_pixel(mode, i, base));
    end
    lower_valid();
  endtask

  // long row count register: send a few rows, then cut the image short
  task automatic tall_image(input logic [15:0] hdata, input int rows);
    int i;
    write_reg(REG_WIDTH, 16'd1);
    write_reg(REG_HEIGHT, hdata);
    for (i = 0; i < rows; i++) send_pixel(8'($urandom));
    lower_valid();
    write_reg(REG_HEIGHT, 16'd1);
    send_pixel(8'($urandom));
    lower_valid();
  endtask

  // output checker
  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: byte %02h last %b eoi %b",
                   out_byte, out_last_of_run, out_end_of_image);
      end else begin
        want = pending_words.pop_front();
        if (out_byte !== want.data || out_last_of_run !== want.last ||
            out_end_of_image !== want.eoi) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: exp byte %02h last %b eoi %b, got %02h %b %b",
                     want.data, want.last, want.eoi,
                     out_byte, out_last_of_run, out_end_of_image);
        end
      end
    end
  end

  // receiver ready: random stall bursts, plus one long hold when asked
  initial begin
    int burst;
    int hold;
    burst = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (quiet || !rst_n) begin
        out_ready <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d words still expected", pending_words.size());
      $display("** predictive_row_bitpack_encoder: FAILED **");
      $finish;
    end
  end

  dir_step_t dir_steps[$];

  initial begin
    int i, phase, wv, hv;
    logic [15:0] wd;
    for (i = 0; i < ROWBUF; i++) begin
      up_row[i] = '0;
      this_row[i] = '0;
      resid_row[i] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    row_lo = '0;
    row_hi = '0;
    spill_bits = '0;
    spill_cnt = 0;
    width_reg = 6'd32;
    height_reg = 16'd1;

    // directed: single-pixel images at the extremes, then a small 4x2 image and a flat 3x1 image
    dir_steps = '{
      '{ST_SET_W, 16'd1, 0, 8'h00, 8'h00},
      '{ST_SET_H, 16'd1, 0, 8'h00, 8'h00},
      '{ST_PIXEL, 16'h00, 1, 8'h00, 8'h00},
      '{ST_PIXEL, 16'hFF, 1, 8'hFF, 8'h00},
      '{ST_PIXEL, 16'h80, 1, 8'h80, 8'h00},
      '{ST_SET_W, 16'd4, 0, 8'h00, 8'h00},
      '{ST_SET_H, 16'd2, 0, 8'h00, 8'h00},
      '{ST_PIXEL, 16'h00, 0, 8'h00, 8'h00},
      '{ST_PIXEL, 16'hFF, 0, 8'h00, 8'h00},
      '{ST_PIXEL, 16'h00, 0, 8'h00, 8'h00},
      '{ST_PIXEL, 16'hFF, 0, 8'h00, 8'h00},
      '{ST_PIXEL, 16'h7F, 0, 8'h00, 8'h00},
      '{ST_PIXEL, 16'h80, 0, 8'h00, 8'h00},
      '{ST_PIXEL, 16'h01, 0, 8'h00, 8'h00},
      '{ST_PIXEL, 16'hFE, 0, 8'h00, 8'h00},
      '{ST_SET_W, 16'd3, 0, 8'h00, 8'h00},
      '{ST_SET_H, 16'd1, 0, 8'h00, 8'h00},
      '{ST_PIXEL, 16'h40, 0, 8'h00, 8'h00},
      '{ST_PIXEL, 16'h40, 0, 8'h00, 8'h00},
      '{ST_PIXEL, 16'h40, 0, 8'h00, 8'h00}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_steps[s]) begin
      case (dir_steps[s].kind)
        ST_SET_W: write_reg(REG_WIDTH, dir_steps[s].value);
        ST_SET_H: write_reg(REG_HEIGHT, dir_steps[s].value);
        default: begin
          send_pixel(dir_steps[s].value[7:0]);
          // a lone pixel packs as: pixel, zero length, zero pad
          if (dir_steps[s].typed) begin
            if (row_words.size() != 2 || row_words[0].data !== dir_steps[s].byte0 ||
                row_words[1].data !== dir_steps[s].byte1 || row_words[1].eoi !== 1'b1) begin
              mismatches++;
              if (mismatches <= 10)
                $display("single-pixel image %02h predicted wrongly", dir_steps[s].value);
            end
          end
        end
      endcase
    end
    lower_valid();

    // zero and maximum row counts, cut short
    tall_image(16'd0, 20);
    tall_image(16'hFFFF, 12);

    // random phases: width zero, an oversize width, full width, another oversize width, then random sizes
    phase = 0;
    while (pixels_sent < 350) begin
      case (phase)
        0: wd = 16'hFFC0;
        1: wd = {10'($urandom), 6'd45};
        2: wd = 16'd32;
        3: wd = {10'($urandom), 6'd63};
        default: begin
          wv = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
          wd = {10'($urandom), 6'(wv)};
        end
      endcase
      hv = $urandom_range(1, 4);
      if (phase == 1) hold_req = 1'b1;
      if (pixels_sent > 280) quiet = 1'b1;
      run_phase(wd, 16'(hv), (wd[5:0] > 8 || wd[5:0] == 0) ? 1 : $urandom_range(1, 3));
      phase++;
    end

    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d pixels in %0d images over %0d phases, %0d output words",
             pixels_sent, images_done, phase, words_seen);
    if (mismatches > 0) $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("** predictive_row_bitpack_encoder: PASSED **");
    end else begin
      $display("** predictive_row_bitpack_encoder: FAILED **");
    end
    $finish;
  end

endmodule
